FILE: rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants for the Catmull-Rom spline sampler
// Coordinate widths, padding weights and the lane control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package crs_pkg;
  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int SampWidth  = 6;
  localparam int AccWidth   = CoordWidth + FracBits + 8;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [FracBits-1:0]          frac_t;
  typedef logic [SampWidth-1:0]         samp_t;

  // Padding weights, round(w * 2^F)
  localparam logic [FracBits:0] W033  = (FracBits+1)'((33 * (64'd1 << FracBits) + 50) / 100);
  localparam logic [FracBits:0] W066  = (FracBits+1)'((66 * (64'd1 << FracBits) + 50) / 100);
  localparam logic [FracBits:0] WHALF = (FracBits+1)'(64'd1 << (FracBits - 1));

  typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_SAMPLE, ST_LAST} state_t;

  // Per-sample control sent from the sequencer to the lanes
  typedef struct packed {
    logic  go;
    frac_t t;
    frac_t t2;
    frac_t t3;
  } lane_ctl_t;

  // a + floor(((b-a)*w + 2^(F-1)) / 2^F)
  function automatic coord_t lerp(input coord_t a, input coord_t b,
                                  input logic [FracBits:0] w);
    logic signed [CoordWidth:0]            diff;
    logic signed [CoordWidth+FracBits+2:0] prod;
    diff = (CoordWidth+1)'(b) - (CoordWidth+1)'(a);
    prod = diff * $signed({1'b0, w}) + $signed((CoordWidth+FracBits+3)'(WHALF));
    lerp = coord_t'(a + coord_t'(prod >>> FracBits));
  endfunction
endpackage
`default_nettype wire

FILE: rtl/crs_if.sv
// ----------------------------------------------------------------------------
// crs_vtx_if / crs_pt_if: valid/ready channels for vertices and points
// One word per accepted handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface crs_vtx_if;
  logic                 valid;
  logic                 ready;
  crs_pkg::coord_t      vertex_x;
  crs_pkg::coord_t      vertex_y;
  crs_pkg::coord_t      vertex_z;
  logic                 final_vertex;
  modport source (output valid, vertex_x, vertex_y, vertex_z, final_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, final_vertex, output ready);
endinterface

interface crs_pt_if;
  logic                 valid;
  logic                 ready;
  crs_pkg::coord_t      point_x;
  crs_pkg::coord_t      point_y;
  crs_pkg::coord_t      point_z;
  logic                 end_of_curve;
  modport source (output valid, point_x, point_y, point_z, end_of_curve, input ready);
  modport sink   (input valid, point_x, point_y, point_z, end_of_curve, output ready);
endinterface
`default_nettype wire

FILE: rtl/catmull_rom_spline_sampler.sv
// ----------------------------------------------------------------------------
// catmull_rom_spline_sampler: streaming uniform Catmull-Rom sampler
// Window, sequencer, three coordinate lanes and an output register.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : vertex words (Q16.16 x/y/z plus final_vertex), valid/ready.
//  out_* : point words (Q16.16 x/y/z plus end_of_curve), valid/ready.
//  cfg_* : cfg_we/cfg_wdata write samples_per_segment (0 acts as 1),
//          only while idle.
//  One vertex is taken at a time. Once the window is full, a vertex
//  accepted starts a serial division of 2^F by S; the point words then
//  pass the t/t2/t3 pipe (stages b and c), the lane products and the
//  output register, one point per cycle while the receiver takes them;
//  a final vertex adds its own word after the last point. The next
//  vertex is taken only once the last word has left the output
//  register. The pad step of a short stream runs during the division.
//  Early vertices give no words.
//  Reset (rst_n low, synchronous) clears the window, the counter and
//  sets S to 16. A stalled receiver holds the output register and the
//  whole sample pipe waits; nothing is dropped.
`default_nettype none
module catmull_rom_spline_sampler (
  input  wire     clk,
  input  wire     rst_n,
  crs_vtx_if.sink in_ch,
  crs_pt_if.source out_ch,
  input  wire     cfg_we,
  input  crs_pkg::samp_t cfg_wdata
);
  import crs_pkg::*;

  samp_t  s_r;
  coord_t wx_r [4], wy_r [4], wz_r [4];
  logic [2:0] seen_r;
  state_t st_r, st_nxt;
  logic   fin_r, pad3_r, pad2_r;
  samp_t  j_r;
  logic   pv_r;           // lane products hold a sample
  logic   hold;
  logic   tg_start, tg_step, tg_busy, tg_vld, tg_pend;
  frac_t  t, t2, t3;
  lane_ctl_t ctl;
  coord_t px, py, pz;
  logic   ov_r; coord_t ox_r, oy_r, oz_r; logic oe_r;
  samp_t  s_eff;
  logic   acc;
  logic [2:0] seen_n;

  assign s_eff = (s_r == '0) ? samp_t'(1) : s_r;
  assign hold  = ov_r && !out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && !tg_pend && !pv_r && !ov_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign seen_n = (seen_r < 3'd4) ? seen_r + 3'd1 : seen_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (acc) begin
        if (seen_n >= 3'd4) st_nxt = ST_SAMPLE;
        else if (in_ch.final_vertex && seen_n >= 3'd2) st_nxt = ST_PAD;
      end
      ST_PAD:    st_nxt = ST_SAMPLE;
      ST_SAMPLE: if (!tg_busy && !tg_start && !hold && j_r == s_eff - samp_t'(1))
                   st_nxt = fin_r ? ST_LAST : ST_IDLE;
      // leave once the end word is loaded into the output register
      ST_LAST:   if (!hold && !tg_pend && !pv_r) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tg_start = 1'b0; tg_step = 1'b0;
    unique case (st_r)
      ST_IDLE:   tg_start = acc;
      ST_SAMPLE: tg_step = !tg_busy && !hold;
      default:   ;
    endcase
  end

  crs_tgen u_tgen (.clk, .rst_n, .start(tg_start), .step(tg_step), .adv(!hold),
                   .s(s_eff), .t, .t2, .t3, .vld(tg_vld), .pend(tg_pend),
                   .busy(tg_busy));

  assign ctl = '{go: tg_vld && !hold, t: t, t2: t2, t3: t3};

  crs_lane u_lx (.clk, .ctl, .p0(wx_r[0]), .p1(wx_r[1]), .p2(wx_r[2]), .p3(wx_r[3]), .point(px));
  crs_lane u_ly (.clk, .ctl, .p0(wy_r[0]), .p1(wy_r[1]), .p2(wy_r[2]), .p3(wy_r[3]), .point(py));
  crs_lane u_lz (.clk, .ctl, .p0(wz_r[0]), .p1(wz_r[1]), .p2(wz_r[2]), .p3(wz_r[3]), .point(pz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; s_r <= samp_t'(16); seen_r <= '0; pv_r <= 1'b0; ov_r <= 1'b0;
      j_r <= '0;
      for (int i = 0; i < 4; i++) begin
        wx_r[i] <= '0; wy_r[i] <= '0; wz_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we) s_r <= cfg_wdata;
      if (acc) begin
        for (int i = 0; i < 3; i++) begin
          wx_r[i] <= wx_r[i+1]; wy_r[i] <= wy_r[i+1]; wz_r[i] <= wz_r[i+1];
        end
        wx_r[3] <= in_ch.vertex_x; wy_r[3] <= in_ch.vertex_y; wz_r[3] <= in_ch.vertex_z;
        fin_r  <= in_ch.final_vertex;
        pad2_r <= (seen_n == 3'd2);
        pad3_r <= (seen_n == 3'd3);
        seen_r <= in_ch.final_vertex ? 3'd0 : seen_n;
        j_r    <= '0;
      end
      if (st_r == ST_PAD) begin
        if (pad2_r) begin
          wx_r[0] <= wx_r[2]; wx_r[1] <= lerp(wx_r[2], wx_r[3], W033);
          wx_r[2] <= lerp(wx_r[2], wx_r[3], W066);
          wy_r[0] <= wy_r[2]; wy_r[1] <= lerp(wy_r[2], wy_r[3], W033);
          wy_r[2] <= lerp(wy_r[2], wy_r[3], W066);
          wz_r[0] <= wz_r[2]; wz_r[1] <= lerp(wz_r[2], wz_r[3], W033);
          wz_r[2] <= lerp(wz_r[2], wz_r[3], W066);
        end else begin
          wx_r[0] <= wx_r[1]; wx_r[1] <= wx_r[2]; wx_r[2] <= lerp(wx_r[2], wx_r[3], WHALF);
          wy_r[0] <= wy_r[1]; wy_r[1] <= wy_r[2]; wy_r[2] <= lerp(wy_r[2], wy_r[3], WHALF);
          wz_r[0] <= wz_r[1]; wz_r[1] <= wz_r[2]; wz_r[2] <= lerp(wz_r[2], wz_r[3], WHALF);
        end
      end
      if (!hold) begin
        pv_r <= ctl.go;
        if (tg_step) j_r <= j_r + samp_t'(1);
        // lane results are ready the cycle after the products load
        if (pv_r) begin
          ov_r <= 1'b1; ox_r <= px; oy_r <= py; oz_r <= pz; oe_r <= 1'b0;
        end else if (st_r == ST_LAST && !tg_pend) begin
          ov_r <= 1'b1; ox_r <= wx_r[3]; oy_r <= wy_r[3]; oz_r <= wz_r[3]; oe_r <= 1'b1;
        end else begin
          ov_r <= 1'b0;
        end
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.point_x = ox_r;
  assign out_ch.point_y = oy_r;
  assign out_ch.point_z = oz_r;
  assign out_ch.end_of_curve = oe_r;

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r) else $error("output dropped");
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= 3'd4) else $error("count overflow");
`endif
endmodule
`default_nettype wire

FILE: rtl/crs_lane.sv
// ----------------------------------------------------------------------------
// crs_lane: one coordinate of the spline evaluator
// Two stages: coefficient products, then sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module crs_lane (
  input  wire                 clk,
  input  crs_pkg::lane_ctl_t  ctl,
  input  crs_pkg::coord_t     p0,
  input  crs_pkg::coord_t     p1,
  input  crs_pkg::coord_t     p2,
  input  crs_pkg::coord_t     p3,
  output crs_pkg::coord_t     point
);
  import crs_pkg::*;
  localparam int CW = CoordWidth + 4;
  localparam int PW = CW + FracBits + 1;

  logic signed [CW-1:0] a, b, c, d;
  logic signed [PW-1:0] bt_r, ct_r, dt_r;
  logic signed [CW-1:0] a_r;
  logic signed [AccWidth-1:0] acc;
  logic signed [AccWidth-1:0] hi, lo;
  logic signed [AccWidth-1:0] res;

  always_comb begin
    a = CW'(p1) <<< 1;
    b = CW'(p2) - CW'(p0);
    c = (CW'(p0) <<< 1) - CW'(p1) * 5 + (CW'(p2) <<< 2) - CW'(p3);
    d = -CW'(p0) + CW'(p1) * 3 - CW'(p2) * 3 + CW'(p3);
  end

  // products load only with a new sample, so a stall keeps them
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      a_r  <= a;
      bt_r <= b * $signed({1'b0, ctl.t});
      ct_r <= c * $signed({1'b0, ctl.t2});
      dt_r <= d * $signed({1'b0, ctl.t3});
    end
  end

  always_comb begin
    acc = (AccWidth'(a_r) <<< FracBits) + AccWidth'(bt_r) + AccWidth'(ct_r)
          + AccWidth'(dt_r) + (AccWidth'(1) <<< FracBits);
    res = acc >>> (FracBits + 1);
    hi  = AccWidth'({1'b0, {(CoordWidth-1){1'b1}}});
    lo  = -hi - 1;
    if (res > hi)      point = coord_t'(hi);
    else if (res < lo) point = coord_t'(lo);
    else               point = coord_t'(res);
  end
endmodule
`default_nettype wire

FILE: rtl/crs_tgen.sv
// ----------------------------------------------------------------------------
// crs_tgen: parameter generator, t = floor(j*2^F/S), t2, t3
// Serial division of 2^F by S once per vertex, then t advances by a
// quotient/remainder step; t2 and t3 come out of a two-stage pipe.
// ----------------------------------------------------------------------------
`default_nettype none
module crs_tgen (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                step,
  input  wire                adv,
  input  crs_pkg::samp_t     s,
  output crs_pkg::frac_t     t,
  output crs_pkg::frac_t     t2,
  output crs_pkg::frac_t     t3,
  output logic               vld,
  output logic               pend,
  output logic               busy
);
  import crs_pkg::*;
  // q and rem come from a restoring division of 2^F by S; t is built from them
  frac_t  q_r, q_nxt, rem_r, rem_nxt, t_r, t_nxt, r_r, r_nxt;
  logic [4:0] k_r, k_nxt;
  logic   busy_r, busy_nxt;
  logic [FracBits:0] trial;
  logic [FracBits:0] rs;
  logic [2*FracBits-1:0] sq, cu;
  // stage b: t and t^2; stage c: t, t^2 and t^3
  frac_t  tb_r, t2b_r, tc_r, t2c_r, t3c_r;
  logic   vb_r, vc_r;

  always_comb begin
    busy_nxt = busy_r; k_nxt = k_r; q_nxt = q_r; rem_nxt = rem_r;
    t_nxt = t_r; r_nxt = r_r;
    trial = {rem_r, 1'b0};
    rs = '0;
    if (start) begin
      busy_nxt = 1'b1; k_nxt = 5'(FracBits); q_nxt = '0; rem_nxt = frac_t'(1);
      t_nxt = '0; r_nxt = '0;
    end else if (busy_r) begin
      if (trial >= (FracBits+1)'(s)) begin
        rem_nxt = frac_t'(trial - (FracBits+1)'(s)); q_nxt = {q_r[FracBits-2:0], 1'b1};
      end else begin
        rem_nxt = frac_t'(trial); q_nxt = {q_r[FracBits-2:0], 1'b0};
      end
      k_nxt = k_r - 5'd1;
      if (k_r == 5'd1) busy_nxt = 1'b0;
    end else if (step) begin
      rs = {1'b0, r_r} + {1'b0, rem_r};
      if (rs >= (FracBits+1)'(s)) begin
        r_nxt = frac_t'(rs - (FracBits+1)'(s)); t_nxt = t_r + q_r + frac_t'(1);
      end else begin
        r_nxt = frac_t'(rs); t_nxt = t_r + q_r;
      end
    end
  end
  // remainder of 2^F mod S: first iteration doubles 1 -> treat as 2^F
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; k_r <= '0; vb_r <= 1'b0; vc_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; k_r <= k_nxt;
      if (adv) begin
        vb_r <= step; vc_r <= vb_r;
      end
    end
    q_r <= q_nxt; rem_r <= rem_nxt; t_r <= t_nxt; r_r <= r_nxt;
    if (adv) begin
      tb_r <= t_r; t2b_r <= sq[2*FracBits-1:FracBits];
      tc_r <= tb_r; t2c_r <= t2b_r; t3c_r <= cu[2*FracBits-1:FracBits];
    end
  end

  always_comb begin
    sq = (2*FracBits)'(t_r) * (2*FracBits)'(t_r);
    cu = (2*FracBits)'(t2b_r) * (2*FracBits)'(tb_r);
  end
  assign t    = tc_r;
  assign t2   = t2c_r;
  assign t3   = t3c_r;
  assign vld  = vc_r;
  assign pend = vb_r | vc_r;
  assign busy = busy_r;
endmodule
`default_nettype wire

FILE: verif/tb_catmull_rom_spline_sampler.sv
// ----------------------------------------------------------------------------
// tb_catmull_rom_spline_sampler: self-checking bench for the spline sampler
// Streams vertex words through the block, predicts every point word from a
// local model of the window and the spline math, and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_catmull_rom_spline_sampler;
  import crs_pkg::*;

  // One pending vertex word; cfg_wr marks a register write between phases
  typedef struct {
    logic   cfg_wr;
    samp_t  samp;
    coord_t vx;
    coord_t vy;
    coord_t vz;
    logic   fin;
  } vtx_item_t;

  typedef struct {
    coord_t px;
    coord_t py;
    coord_t pz;
    logic   eoc;
  } point_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  samp_t cfg_wdata;

  crs_vtx_if vtx_ch ();
  crs_pt_if  pt_ch ();

  catmull_rom_spline_sampler u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (vtx_ch.sink),
    .out_ch   (pt_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  vtx_item_t pending_vtx[$];
  point_t    expected_pts[$];
  int        n_errors;
  int        n_points;
  int        n_vertices;
  int        n_curves;

  // Predictor state: window entry 3 is newest
  longint win_x[4];
  longint win_y[4];
  longint win_z[4];
  int     seen_cnt;
  int     samp_cur;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) gap_len = 0;
    else if (r < 90) gap_len = $urandom_range(1, 3);
    else gap_len = $urandom_range(10, 40);
  endfunction

  function automatic longint floor_sh(longint v, int n);
    floor_sh = v >>> n;
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    mix = a + floor_sh((b - a) * w + 32768, FracBits);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 64'sd2147483647) clamp_coord = 32'h7fffffff;
    else if (v < -64'sd2147483648) clamp_coord = 32'h80000000;
    else clamp_coord = coord_t'(v);
  endfunction

  function automatic longint curve_at(longint p0, longint p1, longint p2, longint p3,
                                      longint t, longint t2, longint t3);
    longint a, b, c, d, acc;
    a = 2 * p1;
    b = p2 - p0;
    c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    d = -p0 + 3 * p1 - 3 * p2 + p3;
    acc = a * 65536 + b * t + c * t2 + d * t3;
    curve_at = floor_sh(acc + 65536, FracBits + 1);
  endfunction

  task automatic queue_segment_points();
    longint s, t, t2, t3;
    point_t p;
    s = (samp_cur == 0) ? 1 : samp_cur;
    for (longint j = 0; j < s; j++) begin
      t = (j << FracBits) / s;
      t2 = floor_sh(t * t, FracBits);
      t3 = floor_sh(t2 * t, FracBits);
      p.px = clamp_coord(curve_at(win_x[0], win_x[1], win_x[2], win_x[3], t, t2, t3));
      p.py = clamp_coord(curve_at(win_y[0], win_y[1], win_y[2], win_y[3], t, t2, t3));
      p.pz = clamp_coord(curve_at(win_z[0], win_z[1], win_z[2], win_z[3], t, t2, t3));
      p.eoc = 1'b0;
      expected_pts.insert(expected_pts.size(), p);
    end
  endtask

  task automatic pad_pair(inout longint w[4]);
    longint a, b;
    a = w[2];
    b = w[3];
    w[0] = a;
    w[1] = mix(a, b, 21627);
    w[2] = mix(a, b, 43254);
    w[3] = b;
  endtask

  task automatic pad_triple(inout longint w[4]);
    longint a, b, c;
    a = w[1];
    b = w[2];
    c = w[3];
    w[0] = a;
    w[1] = b;
    w[2] = mix(b, c, 32768);
    w[3] = c;
  endtask

  // Advance the predictor by one accepted vertex word
  task automatic predict_vertex(vtx_item_t it);
    point_t p;
    for (int i = 0; i < 3; i++) begin
      win_x[i] = win_x[i+1];
      win_y[i] = win_y[i+1];
      win_z[i] = win_z[i+1];
    end
    win_x[3] = longint'(it.vx);
    win_y[3] = longint'(it.vy);
    win_z[3] = longint'(it.vz);
    if (seen_cnt < 4) seen_cnt++;
    if (seen_cnt >= 4) begin
      queue_segment_points();
    end else if (it.fin && seen_cnt == 2) begin
      pad_pair(win_x);
      pad_pair(win_y);
      pad_pair(win_z);
      queue_segment_points();
    end else if (it.fin && seen_cnt == 3) begin
      pad_triple(win_x);
      pad_triple(win_y);
      pad_triple(win_z);
      queue_segment_points();
    end
    if (it.fin) begin
      if (seen_cnt >= 2) begin
        p.px = it.vx;
        p.py = it.vy;
        p.pz = it.vz;
        p.eoc = 1'b1;
        expected_pts.insert(expected_pts.size(), p);
        n_curves++;
      end
      seen_cnt = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Coordinates: mostly moderate values, sometimes the extremes
  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) rand_coord = 32'h7fffffff;
    else if (r == 1) rand_coord = 32'h80000000;
    else if (r < 4) rand_coord = coord_t'($urandom);
    else rand_coord = coord_t'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff);
  endfunction

  task automatic add_vertex(coord_t x, coord_t y, coord_t z, logic fin);
    vtx_item_t it;
    it.cfg_wr = 1'b0;
    it.samp = '0;
    it.vx = x;
    it.vy = y;
    it.vz = z;
    it.fin = fin;
    pending_vtx.insert(pending_vtx.size(), it);
  endtask

  task automatic add_cfg(samp_t s);
    vtx_item_t it;
    it = '{cfg_wr: 1'b1, samp: s, vx: '0, vy: '0, vz: '0, fin: 1'b0};
    pending_vtx.insert(pending_vtx.size(), it);
  endtask

  task automatic add_curve(int len);
    for (int i = 0; i < len; i++)
      add_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
  endtask

  // Driver: one word per handshake; config writes wait for the block to drain
  int     gap_cnt;
  int     drain_cnt;
  logic   cfg_fire;
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    vtx_ch.valid = 1'b0;
    vtx_ch.vertex_x = '0;
    vtx_ch.vertex_y = '0;
    vtx_ch.vertex_z = '0;
    vtx_ch.final_vertex = 1'b0;
    pt_ch.ready = 1'b0;
    gap_cnt = 0;
    drain_cnt = 0;
    cfg_fire = 1'b0;
  end

  always @(posedge clk) begin
    cfg_fire = 1'b0;
    if (rst_n) begin
      if (vtx_ch.valid && vtx_ch.ready) begin
        vtx_item_t acc_it;
        acc_it.cfg_wr = 1'b0;
        acc_it.samp = '0;
        acc_it.vx = vtx_ch.vertex_x;
        acc_it.vy = vtx_ch.vertex_y;
        acc_it.vz = vtx_ch.vertex_z;
        acc_it.fin = vtx_ch.final_vertex;
        predict_vertex(acc_it);
        n_vertices++;
        vtx_ch.valid <= 1'b0;
        gap_cnt = gap_len();
      end else if (!vtx_ch.valid && pending_vtx.size() > 0) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending_vtx[0].cfg_wr) begin
          // Wait until every point is out, then a settle pause for trailing work
          if (expected_pts.size() != 0) drain_cnt = 0;
          else if (drain_cnt < 40) drain_cnt++;
          else begin
            cfg_fire = 1'b1;
            cfg_wdata <= pending_vtx[0].samp;
            samp_cur = pending_vtx[0].samp;
            void'(pending_vtx.pop_front());
            drain_cnt = 0;
          end
        end else begin
          vtx_ch.valid <= 1'b1;
          vtx_ch.vertex_x <= pending_vtx[0].vx;
          vtx_ch.vertex_y <= pending_vtx[0].vy;
          vtx_ch.vertex_z <= pending_vtx[0].vz;
          vtx_ch.final_vertex <= pending_vtx[0].fin;
          void'(pending_vtx.pop_front());
        end
      end
    end
    cfg_we <= cfg_fire;
  end

  // Monitor with random backpressure
  int stall_cnt;
  initial stall_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pt_ch.valid && pt_ch.ready) begin
        if (expected_pts.size() == 0) begin
          report_mismatch("unexpected point word", 0, 0);
        end else begin
          point_t e;
          e = expected_pts.pop_front();
          if (pt_ch.point_x !== e.px) report_mismatch("point_x", pt_ch.point_x, e.px);
          if (pt_ch.point_y !== e.py) report_mismatch("point_y", pt_ch.point_y, e.py);
          if (pt_ch.point_z !== e.pz) report_mismatch("point_z", pt_ch.point_z, e.pz);
          if (pt_ch.end_of_curve !== e.eoc)
            report_mismatch("end_of_curve", pt_ch.end_of_curve, e.eoc);
        end
        n_points++;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        pt_ch.ready <= 1'b0;
      end else begin
        pt_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_cnt = gap_len();
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int ncurve;
    n_errors = 0;
    n_points = 0;
    n_vertices = 0;
    n_curves = 0;
    seen_cnt = 0;
    samp_cur = 16;
    for (int i = 0; i < 4; i++) begin
      win_x[i] = 0;
      win_y[i] = 0;
      win_z[i] = 0;
    end

    // Directed: default S, single/two/three vertex curves, extremes
    add_vertex(32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b1);
    add_vertex(32'sh00000000, 32'sh00000000, 32'sh00000000, 1'b0);
    add_vertex(32'sh00100000, -32'sh00100000, 32'sh00050000, 1'b1);
    add_vertex(32'sh7fffffff, 32'sh80000000, 32'sh00000000, 1'b0);
    add_vertex(32'sh80000000, 32'sh7fffffff, 32'shffffffff, 1'b0);
    add_vertex(32'sh7fffffff, 32'sh80000000, 32'sh00000001, 1'b1);
    add_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    add_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    add_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    add_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    add_vertex(32'sh80000000, 32'sh7fffffff, 32'sh00000000, 1'b1);
    // Zero register acts as one sample per segment
    add_cfg(6'd0);
    add_curve(5);
    add_curve(2);
    add_cfg(6'd63);
    add_curve(4);
    add_cfg(6'd1);
    add_curve(3);
    add_curve(1);

    // Random: curves of varied length; short S settings dominate
    while (n_vertices + pending_vtx.size() < 400) begin
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) add_cfg(samp_t'($urandom_range(0, 63)));
      else if (r < 3) add_cfg(samp_t'($urandom_range(1, 8)));
      ncurve = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 12);
      add_curve(ncurve);
      if (pending_vtx.size() > 420) break;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_vtx.size() == 0 && !vtx_ch.valid && expected_pts.size() == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d vertex words over %0d curves, checked %0d point words.",
             n_vertices, n_curves, n_points);
    if (n_errors == 0 && expected_pts.size() == 0) begin
      $display("tb_catmull_rom_spline_sampler: done, clean");
    end else begin
      $display("tb_catmull_rom_spline_sampler: done, errors");
    end
    $finish;
  end

  // Watchdog: stops the run with an error if it is still going at the time limit
  initial begin
    #200000000;
    $display("Timeout with %0d point words still owed.", expected_pts.size());
    $display("tb_catmull_rom_spline_sampler: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/crs_pkg.sv
rtl/crs_if.sv
rtl/crs_lane.sv
rtl/crs_tgen.sv
rtl/catmull_rom_spline_sampler.sv
verif/tb_catmull_rom_spline_sampler.sv
